>>> rtl/core/tzsm_pkg.sv
// Shared constants, codes and types of the toolpath Z-stitch modulator.
package tzsm_pkg;

  localparam int XW   = 31;   // vertex coordinate width
  localparam int LW   = 40;   // arc length width
  localparam int DW   = 42;   // station distance width
  localparam int ZW   = 18;   // Z offset width
  localparam int AW   = 17;   // clamped amplitude width
  localparam int AMPW = 20;   // amplitude register width
  localparam int SPW  = 27;   // spacing width
  localparam int MFW  = 31;   // foundation width
  localparam int TOPW = 31;
  localparam int HW   = 24;
  localparam int LENW = 32;   // segment length width
  localparam int MULW = 32;   // multiplier operand width
  localparam int NW   = 64;   // dividend and radicand width
  localparam int KW   = 6;
  localparam int CFGW = 31;

  localparam logic [KW-1:0]   MAX_STITCHES_PER_SEGMENT = 6'd63;
  localparam logic [AW-1:0]   AMP_CAP        = 17'd100000;
  localparam logic [SPW-1:0]  SPACING_MIN    = 27'd1250000;
  localparam logic [MFW-1:0]  FOUNDATION_MIN = 31'd350000;
  localparam logic [LENW-1:0] SHORT_SEG      = 32'd100;

  typedef enum logic [1:0] {
    CFG_ENABLE,
    CFG_AMPLITUDE,
    CFG_SPACING,
    CFG_FOUNDATION
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT_ONE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_SUM,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_LEN,
    S_BASE_WAIT,
    S_RANGE,
    S_LOOP,
    S_MX_DIV,
    S_MX_WAIT,
    S_MY_MUL,
    S_MY_DIV,
    S_MY_WAIT,
    S_END,
    S_Z_DIV,
    S_Z_DWAIT,
    S_Z_MUL,
    S_Z_DIV2,
    S_Z_WAIT2,
    S_EMIT_STITCH,
    S_EMIT_FINAL
  } state_t;

endpackage

>>> rtl/core/toolpath_z_stitch_modulator_unit.sv
// Top level of the toolpath Z-stitch modulator: sequencer and datapath.
//
// Takes one polyline vertex per beat and returns its points. A first vertex, a
// pass-through vertex or a vertex of a path that is not stitched gives one
// result; a segment of 100 nm or less gives no result. For a stitched segment,
// one shared divider serves the segment base, each stitch point (two coordinate
// quotients and two for the Z offset) and the offset of the closing vertex when
// it does not end a closed path; one 32-step square root gives the segment
// length. One vertex is worked on at a time; the input is ready again once the
// last result of the vertex sits in the output register.
module toolpath_z_stitch_modulator_unit
  import tzsm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // vertex_x, vertex_y, path_length_nm, layer_top_nm, layer_height_nm, 3'b0
  input  logic [159:0]  s_tdata,
  input  logic          s_tlast,  // last_vertex
  // first_vertex, path_closed, path_eligible
  input  logic [2:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // point_x, point_y, z_offset_nm
  output logic [79:0]   m_tdata,
  output logic          m_tlast,  // run_last
  // stitched, stitch_overflow
  output logic [1:0]    m_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [CFGW-1:0] cfg_data
);

  state_t state, state_next;

  logic            en;
  logic [AMPW-1:0] amp_reg;
  logic [SPW-1:0]  sp;
  logic [MFW-1:0]  mf;

  logic [XW-1:0]   prev_x, prev_y, px, py, in_x, in_y;
  logic            in_last, in_closed, one_st;
  logic [LW-1:0]   arc;
  logic            active;
  logic signed [XW:0] dx, dy;
  logic [NW-1:0]   sumsq;
  logic [LENW-1:0] len;
  logic [DW-1:0]   limit, dpos, zd;
  logic [KW-1:0]   kcnt;
  logic            ovf;
  logic [XW-1:0]   mx, my;
  logic            z_final, zneg;
  logic [SPW:0]    zmag;
  logic [ZW-1:0]   zval;

  logic [XW-1:0]   o_x, o_y;
  logic [ZW-1:0]   o_z;
  logic            o_st, o_last, o_ovf, o_valid;

  // multiplier, divider and root connections
  logic [MULW-1:0]   mul_a, mul_b;
  logic [2*MULW-1:0] mul_p;
  logic              div_start, div_done;
  logic [NW-1:0]     div_n, div_q;
  logic [LENW-1:0]   div_d, div_r;
  logic              sq_start, sq_done;
  logic [LENW-1:0]   sq_root;

  tzsm_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p(mul_p));

  tzsm_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d),
    .quot(div_q), .rem(div_r), .done(div_done)
  );

  tzsm_sqrt u_sqrt (
    .clk, .rst, .start(sq_start), .radicand(sumsq), .root(sq_root), .done(sq_done)
  );

  // input fields
  logic [XW-1:0]   f_x, f_y;
  logic [LW-1:0]   f_plen;
  logic [TOPW-1:0] f_top;
  logic [HW-1:0]   f_height;
  logic            f_first, f_closed, f_elig;

  assign f_x      = s_tdata[30:0];
  assign f_y      = s_tdata[61:31];
  assign f_plen   = s_tdata[101:62];
  assign f_top    = s_tdata[132:102];
  assign f_height = s_tdata[156:133];
  assign f_first  = s_tuser[0];
  assign f_closed = s_tuser[1];
  assign f_elig   = s_tuser[2];

  logic            cfg_ok, gates_ok, accept, out_free, loop_go, o_load;
  logic [AW-1:0]   amp_v;
  logic signed [TOPW+1:0] fnd_h, fnd_a;
  logic [MULW-1:0] absdx, absdy, off;
  logic [DW-1:0]   ovf_pos;
  logic [LW:0]     dist_sum;
  logic signed [SPW+1:0] zdiff;
  logic signed [XW:0] sx, sy;

  assign cfg_ok = en && (amp_reg != '0) && (sp >= SPACING_MIN) && (mf >= FOUNDATION_MIN);
  assign amp_v  = (amp_reg > AMPW'(AMP_CAP)) ? AMP_CAP : amp_reg[AW-1:0];
  assign fnd_h  = $signed({2'b00, f_top}) - $signed({9'd0, f_height}) + 33'sd100;
  assign fnd_a  = $signed({2'b00, f_top}) - $signed({16'd0, amp_v}) + 33'sd100;
  assign gates_ok = cfg_ok && f_elig && !s_tlast
                  && (fnd_h >= $signed({2'b00, mf}))
                  && (fnd_a >= $signed({2'b00, mf}))
                  && (f_plen >= {12'd0, sp, 1'b0});

  assign accept   = s_tvalid && s_tready;
  assign out_free = !o_valid || m_tready;
  assign o_load   = out_free && ((state == S_EMIT_ONE) || (state == S_EMIT_STITCH)
                                 || (state == S_EMIT_FINAL));
  assign absdx    = dx[XW] ? MULW'(-dx) : MULW'(dx);
  assign absdy    = dy[XW] ? MULW'(-dy) : MULW'(dy);
  assign off      = MULW'(dpos - {2'b00, arc});
  assign loop_go  = (dpos < limit) && (kcnt != MAX_STITCHES_PER_SEGMENT);
  assign ovf_pos  = dpos + DW'(sp) * DW'(MAX_STITCHES_PER_SEGMENT);
  assign dist_sum = {1'b0, arc} + (LW+1)'(len);
  assign zdiff    = $signed({2'b00, sp}) - $signed({1'b0, div_r[SPW-1:0], 1'b0});
  assign sx = $signed({px[XW-1], px}) + (dx[XW] ? -$signed({1'b0, mx}) : $signed({1'b0, mx}));
  assign sy = $signed({py[XW-1], py}) + (dy[XW] ? -$signed({1'b0, my}) : $signed({1'b0, my}));

  assign cfg_ready = 1'b1;
  assign m_tvalid  = o_valid;
  assign m_tdata   = {o_z, o_y, o_x};
  assign m_tlast   = o_last;
  assign m_tuser   = {o_ovf, o_st};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (f_first || !active || !cfg_ok) state_next = S_EMIT_ONE;
          else state_next = S_SQ_X;
        end
      end
      S_EMIT_ONE:    if (out_free) state_next = S_IDLE;
      S_SQ_X:        state_next = S_SQ_Y;
      S_SQ_Y:        state_next = S_SQ_SUM;
      S_SQ_SUM:      state_next = S_SQRT_GO;
      S_SQRT_GO:     state_next = S_SQRT_WAIT;
      S_SQRT_WAIT:   if (sq_done) state_next = S_LEN;
      S_LEN:         state_next = (len <= SHORT_SEG) ? S_IDLE : S_BASE_WAIT;
      S_BASE_WAIT:   if (div_done) state_next = S_RANGE;
      S_RANGE:       state_next = S_LOOP;
      S_LOOP:        state_next = loop_go ? S_MX_DIV : S_END;
      S_MX_DIV:      state_next = S_MX_WAIT;
      S_MX_WAIT:     if (div_done) state_next = S_MY_MUL;
      S_MY_MUL:      state_next = S_MY_DIV;
      S_MY_DIV:      state_next = S_MY_WAIT;
      S_MY_WAIT:     if (div_done) state_next = S_Z_DIV;
      S_END:         state_next = (in_last && in_closed) ? S_EMIT_FINAL : S_Z_DIV;
      S_Z_DIV:       state_next = S_Z_DWAIT;
      S_Z_DWAIT:     if (div_done) state_next = S_Z_MUL;
      S_Z_MUL:       state_next = S_Z_DIV2;
      S_Z_DIV2:      state_next = S_Z_WAIT2;
      S_Z_WAIT2:     if (div_done) state_next = z_final ? S_EMIT_FINAL : S_EMIT_STITCH;
      S_EMIT_STITCH: if (out_free) state_next = S_LOOP;
      S_EMIT_FINAL:  if (out_free) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    mul_a     = absdx;
    mul_b     = absdx;
    div_n     = NW'(arc);
    div_d     = LENW'(sp);
    unique case (state)
      S_IDLE:    s_tready = 1'b1;
      S_SQ_Y: begin
        mul_a = absdy;
        mul_b = absdy;
      end
      S_SQRT_GO: sq_start = 1'b1;
      S_LEN:     div_start = (len > SHORT_SEG);
      S_LOOP:    mul_b = off;
      S_MX_DIV: begin
        div_start = 1'b1;
        div_n     = mul_p;
        div_d     = len;
      end
      S_MY_MUL: begin
        mul_a = absdy;
        mul_b = off;
      end
      S_MY_DIV: begin
        div_start = 1'b1;
        div_n     = mul_p;
        div_d     = len;
      end
      S_Z_DIV: begin
        div_start = 1'b1;
        div_n     = NW'(zd);
      end
      S_Z_MUL: begin
        mul_a = MULW'(amp_v);
        mul_b = MULW'(zmag);
      end
      S_Z_DIV2: begin
        div_start = 1'b1;
        div_n     = mul_p;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      en      <= 1'b0;
      amp_reg <= '0;
      sp      <= 27'd1250000;
      mf      <= 31'd350000;
      active  <= 1'b0;
      arc     <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
      o_valid <= 1'b0;
      kcnt    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:     en      <= cfg_data[0];
          CFG_AMPLITUDE:  amp_reg <= cfg_data[AMPW-1:0];
          CFG_SPACING:    sp      <= cfg_data[SPW-1:0];
          CFG_FOUNDATION: mf      <= cfg_data[MFW-1:0];
          default: ;
        endcase
      end
      // load a new beat or drop the one just taken
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            prev_x <= f_x;
            prev_y <= f_y;
            if (f_first) begin
              arc    <= '0;
              active <= gates_ok;
            end else if ((!active || !cfg_ok) && s_tlast) begin
              active <= 1'b0;
            end
          end
        end
        S_LEN:         if (len <= SHORT_SEG && in_last) active <= 1'b0;
        S_RANGE:       kcnt <= '0;
        S_END:         arc <= dist_sum[LW] ? {LW{1'b1}} : dist_sum[LW-1:0];
        S_EMIT_STITCH: if (out_free) kcnt <= kcnt + KW'(1);
        S_EMIT_FINAL:  if (out_free && in_last) active <= 1'b0;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          in_x      <= f_x;
          in_y      <= f_y;
          in_last   <= s_tlast;
          in_closed <= f_closed;
          px        <= prev_x;
          py        <= prev_y;
          dx        <= $signed({f_x[XW-1], f_x}) - $signed({prev_x[XW-1], prev_x});
          dy        <= $signed({f_y[XW-1], f_y}) - $signed({prev_y[XW-1], prev_y});
          one_st    <= f_first && gates_ok;
        end
      end
      S_EMIT_ONE: begin
        if (out_free) begin
          o_x    <= in_x;
          o_y    <= in_y;
          o_z    <= '0;
          o_st   <= one_st;
          o_last <= 1'b1;
          o_ovf  <= 1'b0;
        end
      end
      S_SQ_Y:      sumsq <= mul_p;
      S_SQ_SUM:    sumsq <= sumsq + mul_p;
      S_SQRT_WAIT: if (sq_done) len <= sq_root;
      S_BASE_WAIT: begin
        if (div_done) begin
          // first station past the current arc length
          dpos  <= {2'b00, arc} - DW'(div_r) + DW'(sp);
          limit <= {2'b00, arc} + DW'(len) - DW'(SHORT_SEG);
        end
      end
      S_RANGE:   ovf <= (ovf_pos < limit);
      S_MX_WAIT: if (div_done) mx <= div_q[XW-1:0];
      S_MY_WAIT: begin
        if (div_done) begin
          my      <= div_q[XW-1:0];
          zd      <= dpos;
          z_final <= 1'b0;
        end
      end
      S_END: begin
        zd      <= DW'(dist_sum[LW] ? {LW{1'b1}} : dist_sum[LW-1:0]);
        z_final <= 1'b1;
        zval    <= '0;
      end
      S_Z_DWAIT: begin
        if (div_done) begin
          if (div_q == '0) begin
            zmag <= (SPW+1)'(div_r[SPW-1:0]);
            zneg <= 1'b0;
          end else begin
            zmag <= zdiff[SPW+1] ? (SPW+1)'(-zdiff) : (SPW+1)'(zdiff);
            // odd stations fall from +amp, even ones rise from -amp
            zneg <= div_q[0] ? zdiff[SPW+1] : !zdiff[SPW+1];
          end
        end
      end
      S_Z_WAIT2: begin
        if (div_done) zval <= zneg ? ZW'(-div_q[ZW-1:0]) : div_q[ZW-1:0];
      end
      S_EMIT_STITCH: begin
        if (out_free) begin
          o_x    <= sx[XW-1:0];
          o_y    <= sy[XW-1:0];
          o_z    <= zval;
          o_st   <= 1'b1;
          o_last <= 1'b0;
          o_ovf  <= ovf;
          dpos   <= dpos + DW'(sp);
        end
      end
      S_EMIT_FINAL: begin
        if (out_free) begin
          o_x    <= in_x;
          o_y    <= in_y;
          o_z    <= zval;
          o_st   <= 1'b1;
          o_last <= 1'b1;
          o_ovf  <= ovf;
        end
      end
      default: ;
    endcase
  end

  a_pass_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (!m_tuser[1] && m_tdata[79:62] == '0))
    else $error("pass-through point carries offset or overflow");

  a_stitch_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_STITCH) |-> (kcnt < MAX_STITCHES_PER_SEGMENT))
    else $error("stitch count past cap");

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[79:62]) <= $signed(18'sd100000)
               && $signed(m_tdata[79:62]) >= $signed(-18'sd100000)))
    else $error("Z offset out of range");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_FINAL && out_free) |=> (m_tvalid && m_tlast && m_tuser[0]))
    else $error("closing point not marked last");

endmodule

>>> rtl/core/tzsm_mul.sv
// Shared unsigned multiplier with a registered product.
module tzsm_mul
  import tzsm_pkg::*;
(
  input  logic              clk,
  input  logic [MULW-1:0]   a,
  input  logic [MULW-1:0]   b,
  output logic [2*MULW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/core/tzsm_div.sv
// Restoring divider, one quotient bit per cycle.
module tzsm_div
  import tzsm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   dividend,
  input  logic [LENW-1:0] divisor,
  output logic [NW-1:0]   quot,
  output logic [LENW-1:0] rem,
  output logic            done
);

  logic            busy;
  logic [5:0]      cnt;
  logic [NW-1:0]   q;
  logic [LENW-1:0] r;
  logic [LENW-1:0] dvs;
  logic [LENW:0]   trial;
  logic [LENW:0]   diff;

  assign trial = {r, q[NW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign quot  = q;
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      r   <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[LENW]) begin
        r <= diff[LENW-1:0];
        q <= {q[NW-2:0], 1'b1};
      end else begin
        r <= trial[LENW-1:0];
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/core/tzsm_sqrt.sv
// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
module tzsm_sqrt
  import tzsm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   radicand,
  output logic [LENW-1:0] root,
  output logic            done
);

  logic            busy;
  logic [4:0]      cnt;
  logic [NW-1:0]   s;
  logic [LENW-1:0] rt;
  logic [LENW+1:0] rm;
  logic [LENW+3:0] rm_sh;
  logic [LENW+3:0] trial;

  assign rm_sh = {rm, s[NW-1:NW-2]};
  assign trial = {2'b00, rt, 2'b01};
  // round up when the remainder exceeds the root
  assign root  = rt + LENW'(rm > {2'b00, rt});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s  <= radicand;
      rt <= '0;
      rm <= '0;
    end else if (busy) begin
      s <= {s[NW-3:0], 2'b00};
      if (rm_sh >= trial) begin
        rm <= (LENW+2)'(rm_sh - trial);
        rt <= {rt[LENW-2:0], 1'b1};
      end else begin
        rm <= rm_sh[LENW+1:0];
        rt <= {rt[LENW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> tb/toolpath_z_stitch_modulator_unit_test.sv
// Self-checking testbench for the toolpath Z-stitch modulator top level.
`timescale 1ns / 100ps

module toolpath_z_stitch_modulator_unit_test;
  import tzsm_pkg::*;

  localparam longint unsigned MASK40     = 64'hFF_FFFF_FFFF;
  localparam int              CYCLE_CAP  = 4000000;
  localparam int              SETTLE     = 300;

  typedef struct {
    longint      x, y;
    bit          first, last, closed, elig;
    logic [39:0] plen;
    logic [30:0] top;
    logic [23:0] ht;
  } vertex_t;

  typedef struct {
    logic [30:0] px, py;
    logic [17:0] z;
    bit          stitched, last, ovf;
  } point_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [159:0]   s_tdata = '0;
  logic           s_tlast = 1'b0;
  logic [2:0]     s_tuser = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [79:0]    m_tdata;
  logic           m_tlast;
  logic [1:0]     m_tuser;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_index = '0;
  logic [CFGW-1:0] cfg_data = '0;

  toolpath_z_stitch_modulator_unit uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow registers and path state
  longint unsigned sh_enable, sh_amp, sh_spacing, sh_found;
  longint          last_x, last_y;
  longint unsigned arc_nm;
  bit              path_on;

  point_t point_q[$];
  int     fail_count = 0;
  int     vertex_count = 0;
  int     point_count = 0;
  int     cycle_count = 0;
  int     src_idle = 0;
  int     snk_stall = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("toolpath_z_stitch_modulator_unit test failed");
      $finish;
    end
  end

  always @(negedge clk) m_tready = ($urandom_range(99) >= snk_stall);

  always @(posedge clk) begin
    point_t e;
    if (!rst && m_tvalid && m_tready) begin
      point_count++;
      if (point_q.size() == 0) begin
        $error("unexpected point beat x=%h y=%h", m_tdata[30:0], m_tdata[61:31]);
        fail_count++;
      end else begin
        e = point_q.pop_front();
        if (m_tdata[30:0] !== e.px) begin
          $error("point_x expected %h actual %h", e.px, m_tdata[30:0]); fail_count++;
        end
        if (m_tdata[61:31] !== e.py) begin
          $error("point_y expected %h actual %h", e.py, m_tdata[61:31]); fail_count++;
        end
        if (m_tdata[79:62] !== e.z) begin
          $error("z_offset_nm expected %h actual %h", e.z, m_tdata[79:62]); fail_count++;
        end
        if (m_tuser[0] !== e.stitched) begin
          $error("stitched expected %b actual %b", e.stitched, m_tuser[0]); fail_count++;
        end
        if (m_tlast !== e.last) begin
          $error("run_last expected %b actual %b", e.last, m_tlast); fail_count++;
        end
        if (m_tuser[1] !== e.ovf) begin
          $error("stitch_overflow expected %b actual %b", e.ovf, m_tuser[1]); fail_count++;
        end
      end
    end
  end

  function automatic longint unsigned round_root(longint unsigned s);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s > r) r++;
    return r;
  endfunction

  function automatic bit regs_allow();
    return sh_enable != 0 && sh_amp > 0 && sh_spacing >= 1250000 && sh_found >= 350000;
  endfunction

  function automatic longint amp_clamped();
    return sh_amp > 100000 ? 100000 : longint'(sh_amp);
  endfunction

  function automatic longint station_level(longint unsigned st);
    if (st == 0) return 0;
    return st[0] ? amp_clamped() : -amp_clamped();
  endfunction

  function automatic longint wave_offset(longint unsigned d);
    longint unsigned st, r;
    longint a, b, s;
    if (d == 0) return 0;
    s  = longint'(sh_spacing);
    st = d / sh_spacing;
    r  = d % sh_spacing;
    a  = station_level(st);
    b  = station_level(st + 1);
    return (a * s + (b - a) * longint'(r)) / s;
  endfunction

  task automatic add_point(longint x, longint y, longint z, bit st, bit lst, bit ovf);
    point_t p;
    p.px = x[30:0];
    p.py = y[30:0];
    p.z  = z[17:0];
    p.stitched = st;
    p.last = lst;
    p.ovf = ovf;
    point_q.push_back(p);
  endtask

  task automatic predict_points(vertex_t v);
    longint px, py, dx, dy, mf, adx, ady, sx, sy;
    longint unsigned len, arc_pos, sp, nxt, lim, cnt, n, d, off, mx, my;
    bit ovf;
    px = last_x;
    py = last_y;
    last_x = v.x;
    last_y = v.y;
    mf = longint'(sh_found);
    if (v.first) begin
      arc_nm = 0;
      path_on = regs_allow() && v.elig && !v.last
        && longint'(v.top) - longint'(v.ht) + 100 >= mf
        && longint'(v.top) - amp_clamped() + 100 >= mf
        && longint'(v.plen) >= 2 * longint'(sh_spacing);
      add_point(v.x, v.y, 0, path_on, 1, 0);
      if (v.last) path_on = 0;
      return;
    end
    if (!path_on || !regs_allow()) begin
      if (v.last) path_on = 0;
      add_point(v.x, v.y, 0, 0, 1, 0);
      return;
    end
    dx  = v.x - px;
    dy  = v.y - py;
    len = round_root(longint'(dx * dx) + longint'(dy * dy));
    if (len <= 100) begin
      if (v.last) path_on = 0;
      return;
    end
    arc_pos = arc_nm;
    sp      = sh_spacing;
    nxt     = (arc_pos / sp + 1) * sp;
    lim     = arc_pos + len - 100;
    cnt     = nxt < lim ? (lim - nxt - 1) / sp + 1 : 0;
    ovf     = cnt > 63;
    n       = ovf ? 63 : cnt;
    adx     = dx < 0 ? -dx : dx;
    ady     = dy < 0 ? -dy : dy;
    for (longint unsigned k = 0; k < n; k++) begin
      d   = nxt + k * sp;
      off = d - arc_pos;
      mx  = longint'(adx) * off / len;
      my  = longint'(ady) * off / len;
      sx  = px + (dx < 0 ? -longint'(mx) : longint'(mx));
      sy  = py + (dy < 0 ? -longint'(my) : longint'(my));
      add_point(sx, sy, wave_offset(d), 1, 0, ovf);
    end
    arc_pos += len;
    if (arc_pos > MASK40) arc_pos = MASK40;
    arc_nm = arc_pos;
    add_point(v.x, v.y, (v.last && v.closed) ? 0 : wave_offset(arc_pos), 1, 1, ovf);
    if (v.last) path_on = 0;
  endtask

  task automatic send_vertex(vertex_t v);
    logic [30:0] xb, yb;
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    xb = v.x[30:0];
    yb = v.y[30:0];
    s_tdata  = {3'b000, v.ht, v.top, v.plen, yb, xb};
    s_tlast  = v.last;
    s_tuser  = {v.elig, v.closed, v.first};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    vertex_count++;
    predict_points(v);
  endtask

  // drop valid, wait for every point, then let a short segment finish
  task automatic drain_points();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, longint unsigned val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val[CFGW-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE:     sh_enable  = val & 1;
      CFG_AMPLITUDE:  sh_amp     = val & 20'hFFFFF;
      CFG_SPACING:    sh_spacing = val & 27'h7FFFFFF;
      CFG_FOUNDATION: sh_found   = val & 31'h7FFFFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(longint unsigned en, amp, sp, mf);
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_AMPLITUDE, amp);
    write_reg(CFG_SPACING, sp);
    write_reg(CFG_FOUNDATION, mf);
  endtask

  function automatic vertex_t vtx(longint x, longint y, bit f, bit l, bit c, bit e,
                                  longint unsigned plen = 64'd1000000000,
                                  longint unsigned top = 64'd5000000,
                                  longint unsigned ht = 64'd200000);
    vertex_t v;
    v.x = x; v.y = y; v.first = f; v.last = l; v.closed = c; v.elig = e;
    v.plen = plen[39:0]; v.top = top[30:0]; v.ht = ht[23:0];
    return v;
  endfunction

  function automatic vertex_t noise_vertex();
    vertex_t v;
    longint unsigned pl;
    pl = {$urandom, $urandom};
    v = vtx(longint'($urandom_range(2000000000)) - 1000000000,
            longint'($urandom_range(2000000000)) - 1000000000,
            $urandom, $urandom, $urandom, $urandom, pl & MASK40,
            $urandom_range(2000000000), $urandom_range(10000000));
    return v;
  endfunction

  task automatic test_pass_through();
    send_vertex(vtx(-1000000000, 1000000000, 1, 0, 0, 1));
    send_vertex(vtx(1000000000, -1000000000, 0, 0, 1, 1, MASK40, 2000000000, 10000000));
    send_vertex(vtx(0, 0, 0, 1, 1, 0, 0, 0, 0));
    send_vertex(vtx(12345, -678, 0, 0, 0, 1));
    send_vertex(vtx(7, 7, 1, 1, 0, 1));
    drain_points();
  endtask

  task automatic test_stitched_paths();
    set_regs(1, 50000, 1250000, 350000);
    send_vertex(vtx(0, 0, 1, 0, 1, 1));
    send_vertex(vtx(3000000, 0, 0, 0, 1, 1));
    send_vertex(vtx(3000050, 0, 0, 0, 1, 1));
    send_vertex(vtx(3000000, 4000000, 0, 0, 1, 1));
    send_vertex(vtx(0, 0, 0, 1, 1, 1));
    // missing first vertex
    send_vertex(vtx(500, 500, 0, 0, 0, 1));
    // one-vertex path, ineligible, layer gate, short path
    send_vertex(vtx(1, 2, 1, 1, 0, 1));
    send_vertex(vtx(1, 2, 1, 0, 0, 0));
    send_vertex(vtx(1, 2, 1, 0, 0, 1, 1000000000, 400000, 200000));
    send_vertex(vtx(1, 2, 1, 0, 0, 1, 2499999));
    // open path ending off zero, then one over the stitch cap
    send_vertex(vtx(-1000000, 0, 1, 0, 0, 1));
    send_vertex(vtx(2000000, 2000000, 0, 0, 0, 1));
    send_vertex(vtx(2000000, 102000000, 0, 1, 0, 1));
    drain_points();
    // registers flipped mid-path
    send_vertex(vtx(0, 0, 1, 0, 0, 1));
    send_vertex(vtx(2600000, 0, 0, 0, 0, 1));
    drain_points();
    write_reg(CFG_ENABLE, 0);
    send_vertex(vtx(5200000, 0, 0, 0, 0, 1));
    drain_points();
    write_reg(CFG_ENABLE, 1);
    send_vertex(vtx(7800000, 0, 0, 1, 0, 1));
    drain_points();
    // register extremes: clamped amplitude, a wide spacing, corner to corner
    set_regs(1, 1000000, 100000000, 350000);
    send_vertex(vtx(-1000000000, -1000000000, 1, 0, 0, 1, MASK40, 2000000000, 0));
    send_vertex(vtx(1000000000, 1000000000, 0, 1, 0, 1));
    drain_points();
    set_regs(1, 1, 1250000, 2000000000);
    send_vertex(vtx(0, 0, 1, 0, 0, 1, MASK40, 2000000000, 0));
    send_vertex(vtx(0, -3000000, 0, 1, 1, 1));
    drain_points();
    set_regs(1, 0, 1249999, 349999);
    send_vertex(vtx(0, 0, 1, 0, 0, 1));
    send_vertex(vtx(0, 3000000, 0, 1, 0, 1));
    drain_points();
  endtask

  task automatic test_random_paths(int items, int idle, int stall);
    int      sent = 0;
    int      nv;
    longint  cx, cy;
    vertex_t v;
    src_idle  = idle;
    snk_stall = stall;
    set_regs($urandom_range(99) < 90, $urandom_range(1, 150000),
             $urandom_range(1250000, 3000000), $urandom_range(350000, 400000));
    while (sent < items) begin
      if ($urandom_range(99) < 15) begin
        send_vertex(noise_vertex());
        sent++;
      end else begin
        nv = $urandom_range(2, 7);
        cx = longint'($urandom_range(1800000000)) - 900000000;
        cy = longint'($urandom_range(1800000000)) - 900000000;
        v = vtx(cx, cy, 1, 0, $urandom, $urandom_range(99) < 90,
                $urandom_range(99) < 90 ? 64'd500000000 : $urandom_range(6000000),
                $urandom_range(99) < 90 ? $urandom_range(20000000, 2000000000)
                                        : $urandom_range(600000),
                $urandom_range(10000000));
        send_vertex(v);
        sent++;
        for (int i = 1; i < nv; i++) begin
          if ($urandom_range(99) < 15) begin
            cx += longint'($urandom_range(120)) - 60;
          end else begin
            cx += longint'($urandom_range(6000000)) - 3000000;
            cy += longint'($urandom_range(6000000)) - 3000000;
          end
          v.x = cx; v.y = cy; v.first = 0; v.last = (i == nv - 1);
          send_vertex(v);
          sent++;
        end
      end
      // hold off until the output runs dry
      if (sent >= items / 2 && sent < items / 2 + 8) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        while (point_q.size() != 0) @(posedge clk);
      end
    end
    drain_points();
  endtask

  initial begin
    sh_enable = 0; sh_amp = 0; sh_spacing = 1250000; sh_found = 350000;
    last_x = 0; last_y = 0; arc_nm = 0; path_on = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_pass_through();
    test_stitched_paths();
    test_random_paths(22, 0, 0);
    test_random_paths(22, 62, 0);
    test_random_paths(22, 0, 62);
    test_random_paths(22, 32, 32);
    fail_count += point_q.size();
    $display("Covered %0d vertices and %0d points: pass-through, gates, stitch cap,",
             vertex_count, point_count);
    $display("closed and open paths, register extremes and random paths under back-pressure.");
    if (fail_count == 0) begin
      $display("toolpath_z_stitch_modulator_unit test passed");
    end else begin
      $display("toolpath_z_stitch_modulator_unit test failed");
    end
    $finish;
  end

endmodule
